>>> sv/fdh_pkg.sv
package fdh_pkg;

    // field widths
    localparam int CHAR_W    = 8;
    localparam int ARG_W     = 32;
    localparam int DIGIT_W   = 4;
    localparam int NUM_DIGITS = 10;
    localparam int DIGITS_W  = DIGIT_W * NUM_DIGITS;
    localparam int REMAIN_W  = $clog2(NUM_DIGITS + 1);
    localparam int BITCNT_W  = $clog2(ARG_W + 1);

    // character codes
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A       = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;

    localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

    // control from the sequencer to the character emitter
    typedef struct packed {
        logic load;
        logic neg;
        logic slot_free;
    } emit_ctl_t;

    // status from the character emitter
    typedef struct packed {
        logic busy;
        logic char_valid;
        logic char_last;
    } emit_stat_t;

    // one digit to its ascii character, lowercase for a..f
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_BASE)
            c = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        else
            c = CH_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DEC_BASE};
        return c;
    endfunction

endpackage

>>> sv/fdh_dabble.sv
module fdh_dabble
    import fdh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ARG_W-1:0]    value,
    output logic                done,
    output logic [DIGITS_W-1:0] bcd
);

    logic [ARG_W-1:0]    bin_reg, bin_next;
    logic [DIGITS_W-1:0] bcd_reg, bcd_next;
    logic [BITCNT_W-1:0] left_reg, left_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIGITS_W-1:0] adj;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    // one binary bit shifted into the decimal digits per cycle
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        left_next = left_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            left_next = BITCNT_W'(ARG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[DIGITS_W-2:0], bin_reg[ARG_W-1]};
            bin_next  = {bin_reg[ARG_W-2:0], 1'b0};
            left_next = left_reg - 1'b1;
            if (left_reg == BITCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> sv/fdh_emitter.sv
module fdh_emitter
    import fdh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  emit_ctl_t           ctl,
    input  logic [DIGITS_W-1:0] digits,
    output emit_stat_t          stat,
    output logic [CHAR_W-1:0]   char_out
);

    logic [DIGITS_W-1:0] digits_reg, digits_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic                sign_reg, sign_next;
    logic                started_reg, started_next;
    logic                busy_reg, busy_next;
    logic [DIGIT_W-1:0]  top;
    logic                skip;

    assign top  = digits_reg[DIGITS_W-1 -: DIGIT_W];
    // leading zero digits are dropped, the final digit always prints
    assign skip = (top == '0) && !started_reg && (remain_reg != REMAIN_W'(1));

    // sign first, then one digit per cycle from the most significant end, while the output slot is free
    always_comb
    begin
        digits_next     = digits_reg;
        remain_next     = remain_reg;
        sign_next       = sign_reg;
        started_next    = started_reg;
        busy_next       = busy_reg;
        stat.busy       = busy_reg;
        stat.char_valid = 1'b0;
        stat.char_last  = 1'b0;
        char_out        = digit_char(top);
        if (ctl.load)
        begin
            digits_next  = digits;
            remain_next  = REMAIN_W'(NUM_DIGITS);
            sign_next    = ctl.neg;
            started_next = 1'b0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sign_reg)
            begin
                if (ctl.slot_free)
                begin
                    char_out        = CH_MINUS;
                    stat.char_valid = 1'b1;
                    sign_next       = 1'b0;
                end
            end
            else if (skip)
            begin
                digits_next = {digits_reg[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                remain_next = remain_reg - 1'b1;
            end
            else if (ctl.slot_free)
            begin
                stat.char_valid = 1'b1;
                stat.char_last  = (remain_reg == REMAIN_W'(1));
                digits_next     = {digits_reg[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                remain_next     = remain_reg - 1'b1;
                started_next    = 1'b1;
                if (remain_reg == REMAIN_W'(1))
                    busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg  <= '0;
            sign_reg    <= 1'b0;
            started_reg <= 1'b0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            remain_reg  <= remain_next;
            sign_reg    <= sign_next;
            started_reg <= started_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
    end

endmodule

>>> sv/format_decimal_hex_text_stream.sv
// Small printf-style formatter: each input word carries one format byte and a 32-bit argument.
// Plain bytes are echoed as one character with tlast set; '%' emits nothing and waits for the
// next byte, where 'd' prints the argument as signed decimal, 'x' as lowercase hex without
// leading zeros, and any other byte (a second '%' included) is echoed. Every output word is one
// character, tlast marks the final character of an input word. A plain byte or a '%' leaves
// the sequencer idle; %x loads the argument as ten nibbles into the emitter, which steps
// through them one per cycle while the output slot is free and then returns to idle; %d runs
// the magnitude through the bit-serial binary-to-decimal shifter, loads its ten digits into
// the emitter, which sends the minus sign when negative and then steps through the digit
// positions before idle. Input is taken only in idle between conversions, with a free slot.
module format_decimal_hex_text_stream
    import fdh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [CHAR_W+ARG_W-1:0] s_axis_tdata,   // fmt_char [7:0], arg_value [39:8]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [CHAR_W-1:0]       m_axis_tdata,   // out_char [7:0]
    output logic                    m_axis_tlast
);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

    state_t              state_reg, state_next;
    logic                pending_reg, pending_next;
    logic                neg_reg, neg_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    logic [CHAR_W-1:0]   fmt_char;
    logic [ARG_W-1:0]    arg_value;
    logic                fire;
    logic                slot_free;
    logic                dab_start;
    logic [ARG_W-1:0]    dab_value;
    logic                dab_done;
    logic [DIGITS_W-1:0] dab_bcd;
    emit_ctl_t           ectl;
    emit_stat_t          estat;
    logic [DIGITS_W-1:0] emit_digits;
    logic [CHAR_W-1:0]   emit_char;

    assign fmt_char  = s_axis_tdata[CHAR_W-1:0];
    assign arg_value = s_axis_tdata[CHAR_W+ARG_W-1:CHAR_W];
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && slot_free;
    assign fire = s_axis_tvalid && s_axis_tready;

    // magnitude of a signed argument goes to the decimal shifter
    assign dab_value = arg_value[ARG_W-1] ? (~arg_value + 1'b1) : arg_value;

    fdh_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .value (dab_value),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    fdh_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ectl),
        .digits   (emit_digits),
        .stat     (estat),
        .char_out (emit_char)
    );

    // sequencer and output word register
    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        dab_start      = 1'b0;
        ectl.load      = 1'b0;
        ectl.neg       = 1'b0;
        ectl.slot_free = slot_free;
        emit_digits    = dab_bcd;

        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    if (!pending_reg && fmt_char == CH_PERCENT)
                    begin
                        pending_next = 1'b1;
                    end
                    else if (pending_reg && fmt_char == CH_D)
                    begin
                        pending_next = 1'b0;
                        neg_next     = arg_value[ARG_W-1];
                        dab_start    = 1'b1;
                        state_next   = ST_CONV;
                    end
                    else if (pending_reg && fmt_char == CH_X)
                    begin
                        pending_next = 1'b0;
                        emit_digits  = {{(DIGITS_W-ARG_W){1'b0}}, arg_value};
                        ectl.load    = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        pending_next   = 1'b0;
                        out_valid_next = 1'b1;
                        out_char_next  = fmt_char;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ST_CONV:
            begin
                if (dab_done)
                begin
                    ectl.load  = 1'b1;
                    ectl.neg   = neg_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (estat.char_valid)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = emit_char;
                    out_last_next  = estat.char_last;
                end
                if (!estat.busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> dv/tb_format_decimal_hex_text_stream.sv
module tb_format_decimal_hex_text_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import fdh_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 30;

    localparam logic [ARG_W-1:0] DEC_RADIX = 32'd10;
    localparam logic [ARG_W-1:0] HEX_RADIX = 32'd16;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [CHAR_W+ARG_W-1:0] s_axis_tdata = '0;    // fmt_char [7:0], arg_value [39:8]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]       m_axis_tdata;         // out_char [7:0]
    logic                    m_axis_tlast;

    // predictor state and expected characters
    logic                    pct_armed = 1'b0;
    logic [CHAR_W-1:0]       exp_char_q[$];
    logic                    exp_last_q[$];

    int send_idle_pct  = 8;
    int recv_idle_pct  = 71;
    int words_sent     = 0;
    int chars_checked  = 0;
    int dec_count      = 0;
    int hex_count      = 0;
    int mismatch_count = 0;
    int unsigned cycles = 0;

    format_decimal_hex_text_stream i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    // count one mismatch and print it
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $realtime, msg);
    endtask

    // work out the characters one accepted word produces
    task automatic predict_format(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg);
        logic [CHAR_W-1:0] text[$];
        logic [ARG_W-1:0]  mag;
        logic [ARG_W-1:0]  radix;
        logic [ARG_W-1:0]  dig;
        logic              neg;
        if (!pct_armed)
        begin
            if (ch == CH_PERCENT)
                pct_armed = 1'b1;
            else
                text.push_back(ch);
        end
        else
        begin
            pct_armed = 1'b0;
            if (ch == CH_D || ch == CH_X)
            begin
                neg   = (ch == CH_D) && arg[ARG_W-1];
                mag   = neg ? -arg : arg;
                radix = (ch == CH_D) ? DEC_RADIX : HEX_RADIX;
                if (ch == CH_D)
                    dec_count++;
                else
                    hex_count++;
                // digits come out least significant first, zero gives one digit
                do
                begin
                    dig = mag % radix;
                    if (dig < DEC_RADIX)
                        text.push_front(CH_ZERO + dig[CHAR_W-1:0]);
                    else
                        text.push_front(CH_A + dig[CHAR_W-1:0] - DEC_RADIX[CHAR_W-1:0]);
                    mag = mag / radix;
                end
                while (mag != '0);
                if (neg)
                    text.push_front(CH_MINUS);
            end
            else
            begin
                text.push_back(ch);
            end
        end
        foreach (text[k])
        begin
            exp_char_q.push_back(text[k]);
            exp_last_q.push_back(k == text.size() - 1);
        end
    endtask

    // watch both handshakes, compare each output word, drive receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_format(s_axis_tdata[CHAR_W-1:0], s_axis_tdata[CHAR_W+ARG_W-1:CHAR_W]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (exp_char_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character %02h last %0b",
                                              m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    if (m_axis_tdata !== exp_char_q[0])
                        report_mismatch($sformatf("character got %02h, expected %02h",
                                                  m_axis_tdata, exp_char_q[0]));
                    if (m_axis_tlast !== exp_last_q[0])
                        report_mismatch($sformatf("last on %02h got %0b, expected %0b",
                                                  exp_char_q[0], m_axis_tlast, exp_last_q[0]));
                    void'(exp_char_q.pop_front());
                    void'(exp_last_q.pop_front());
                    chars_checked++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // run guard
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d characters still awaited",
                 cycles, exp_char_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one word, with random gaps in front, and wait for it to be taken
    task automatic send_word(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {arg, ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // argument words biased toward the edges of both conversions
    function automatic logic [ARG_W-1:0] pick_arg();
        logic [ARG_W-1:0] val;
        case ($urandom_range(5))
            0: val = $urandom_range(20);
            1: val = -$urandom_range(1, 20);
            2:
            begin
                case ($urandom_range(3))
                    0: val = 32'h0000_0000;
                    1: val = 32'h7fff_ffff;
                    2: val = 32'h8000_0000;
                    default: val = 32'hffff_ffff;
                endcase
            end
            3: val = $urandom >> $urandom_range(31);
            default: val = $urandom;
        endcase
        return val;
    endfunction

    // plain bytes, the extremes and the conversion letters themselves
    task automatic test_plain_echo();
        send_word(8'h00, 32'hffff_ffff);
        send_word(8'hff, 32'h0000_0000);
        send_word(8'h41, 32'h1234_5678);
        send_word(8'h80, 32'h8000_0000);
        send_word(CH_D, 32'h0000_0001);
        send_word(CH_X, 32'h0000_00ff);
    endtask

    // signed decimal: zero, minus one, both limits
    task automatic test_decimal();
        send_word(CH_PERCENT, $urandom);
        send_word(CH_D, 32'h0000_0000);
        send_word(CH_PERCENT, $urandom);
        send_word(CH_D, 32'hffff_ffff);
        send_word(CH_PERCENT, $urandom);
        send_word(CH_D, 32'h7fff_ffff);
        send_word(CH_PERCENT, $urandom);
        send_word(CH_D, 32'h8000_0000);
    endtask

    // hex without leading zeros: zero and all ones
    task automatic test_hex();
        send_word(CH_PERCENT, $urandom);
        send_word(CH_X, 32'h0000_0000);
        send_word(CH_PERCENT, $urandom);
        send_word(CH_X, 32'hffff_ffff);
    endtask

    // double percent, string conversion and an odd byte after percent
    task automatic test_other_conversion();
        send_word(CH_PERCENT, $urandom);
        send_word(CH_PERCENT, $urandom);
        send_word(CH_PERCENT, $urandom);
        send_word(8'h73, $urandom);
        send_word(CH_PERCENT, $urandom);
        send_word(8'hff, $urandom);
    endtask

    // random format text: plain bytes, conversions with random arguments and odd bytes after percent
    task automatic test_random_text(input int units, input int s_idle, input int r_idle);
        int sel;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (units)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
            begin
                send_word(CHAR_W'($urandom_range(255)), $urandom);
            end
            else if (sel < 65)
            begin
                send_word(CH_PERCENT, $urandom);
                send_word(CH_D, pick_arg());
            end
            else if (sel < 85)
            begin
                send_word(CH_PERCENT, $urandom);
                send_word(CH_X, pick_arg());
            end
            else
            begin
                send_word(CH_PERCENT, $urandom);
                send_word(CHAR_W'($urandom_range(255)), $urandom);
            end
        end
    endtask

    // test sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_echo();
        test_decimal();
        test_hex();
        test_other_conversion();
        test_random_text(85, 8, 71);
        test_random_text(80, 71, 8);
        test_random_text(80, 0, 0);

        s_axis_tvalid <= 1'b0;
        while (exp_char_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d format words (%0d decimal, %0d hex conversions)",
                 words_sent, dec_count, hex_count);
        $display("checked %0d output characters, %0d mismatches",
                 chars_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/fdh_pkg.sv
sv/fdh_dabble.sv
sv/fdh_emitter.sv
sv/format_decimal_hex_text_stream.sv
dv/tb_format_decimal_hex_text_stream.sv
